// ----- hdl/gctm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gctm_pkg;

    // Geometry of the card table
    localparam int MAX_CARDS  = 65536;
    localparam int IDX_W      = $clog2(MAX_CARDS);
    localparam int CNT_W      = 17;
    localparam int ADDR_BITS  = 48;
    localparam int CARD_LSB   = 9;
    localparam int RAW_W      = ADDR_BITS - CARD_LSB;
    localparam int SCAN_SPAN  = 64;
    localparam int SPAN_W     = $clog2(SCAN_SPAN + 1);

    // Card states
    typedef logic [1:0] t_card;
    localparam t_card ST_CLEAN   = 2'd0;
    localparam t_card ST_DIRTY   = 2'd1;
    localparam t_card ST_SCANNED = 2'd2;

    // Request opcodes
    typedef logic [2:0] t_op;
    localparam t_op OP_DIRTY      = 3'd0;
    localparam t_op OP_CLEAN      = 3'd1;
    localparam t_op OP_SCANNED    = 3'd2;
    localparam t_op OP_QUERY      = 3'd3;
    localparam t_op OP_SCAN       = 3'd4;
    localparam t_op OP_CLEAR_ALL  = 3'd5;
    localparam t_op OP_RESET_SCAN = 3'd6;
    localparam t_op OP_COUNT      = 3'd7;

    // Configuration register indexes
    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_CARD_COUNT = 1'b1;

endpackage

`default_nettype wire

// ----- hdl/gc_card_table_marker_core.sv -----
// Card table for a garbage collector: one 2-bit state (clean, dirty, scanned) per 512-byte
// card, held in a 65536-entry single-write, single-read memory with a registered read
// port. One request is worked on at a time. Marks (ops 0-2) and queries (op 3) are
// accepted with a memory read, then updated and answered; the dirty count (op 7) is
// accepted, then answered. A range scan (op 4) is set up, then reads and checks each card
// visited (at most 64 cards), one memory read per card, and gives one result per dirty
// card found (or one empty result). Clear all (op 5) is a write sweep over all 65536
// entries; reset scanned (op 6) is a pipelined read-modify-write sweep over all entries;
// each then gives one result. After reset a clearing pass over all entries runs before
// the first request is accepted; configuration writes are taken at any time. A stall on
// the result channel holds the block wherever a result is due.
`timescale 1ns / 1ps
`default_nettype none

module gc_card_table_marker_core import gctm_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // configuration
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_index,
    input  wire [ADDR_BITS-1:0]  i_cfg_data,
    // request channel
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire [2:0]            i_op,
    input  wire [ADDR_BITS-1:0]  i_address,
    input  wire [ADDR_BITS-1:0]  i_end_address,
    // result channel
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic                 o_hit,
    output logic [ADDR_BITS-1:0] o_card_base,
    output logic                 o_dirty_flag,
    output logic [CNT_W-1:0]     o_count,
    output logic                 o_clipped,
    output logic                 o_last
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MARK  = 4'd1;
    localparam logic [3:0] S_SETUP = 4'd2;
    localparam logic [3:0] S_SRD   = 4'd3;
    localparam logic [3:0] S_SCHK  = 4'd4;
    localparam logic [3:0] S_SEND  = 4'd5;
    localparam logic [3:0] S_CLR   = 4'd6;
    localparam logic [3:0] S_RSW   = 4'd7;
    localparam logic [3:0] S_RTAIL = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CARDS - 1);

    // configuration registers
    logic [ADDR_BITS-1:0] r_heap_base;
    logic [CNT_W-1:0]     r_card_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= '0;
            r_card_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEAP_BASE:  r_heap_base  <= i_cfg_data;
                CFG_CARD_COUNT: r_card_count <= i_cfg_data[CNT_W-1:0];
                default:        r_heap_base  <= r_heap_base;
            endcase
        end
    end

    // card memory
    t_card            r_mem [MAX_CARDS];
    t_card            r_rdata;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    t_card            mem_wd;
    logic             mem_re;
    logic [IDX_W-1:0] mem_ra;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (mem_re) r_rdata <= r_mem[mem_ra];
    end

    // control and working registers
    logic [3:0]           r_state, n_state;
    t_op                  r_op;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_inr;
    logic [IDX_W-1:0]     r_lo;
    logic                 r_lo_ok;
    logic [CNT_W-1:0]     r_hi;
    logic [CNT_W-1:0]     r_cur, n_cur;
    logic [CNT_W-1:0]     r_end, n_end;
    logic                 r_clip, n_clip;
    logic                 r_pend, n_pend;
    logic [ADDR_BITS-1:0] r_pbase, n_pbase;
    logic [SPAN_W-1:0]    r_found, n_found;
    logic [IDX_W-1:0]     r_sw, n_sw;
    logic                 r_pv, n_pv;
    logic [IDX_W-1:0]     r_pa, n_pa;
    logic                 r_clr_op, n_clr_op;
    logic [CNT_W-1:0]     r_dirty_total, n_dirty_total;

    // output register
    logic                 r_o_valid;
    logic                 r_o_hit, r_o_flag, r_o_clip, r_o_last;
    logic [ADDR_BITS-1:0] r_o_base;
    logic [CNT_W-1:0]     r_o_count;
    logic                 load;
    logic                 n_o_hit, n_o_flag, n_o_clip;
    logic [ADDR_BITS-1:0] n_o_base;
    logic [CNT_W-1:0]     n_o_count;

    wire out_free = !r_o_valid || !i_stall;
    wire accept   = i_valid && !o_stall;

    // request address decode
    logic                 a_ge, e_ge, in_range;
    logic [ADDR_BITS-1:0] a_off, e_off;
    logic [RAW_W-1:0]     a_idx, e_idx, cc_ext;
    logic [CNT_W-1:0]     hi_sel, card_lim;

    always_comb begin
        // card count is limited to the table size
        card_lim = (r_card_count > CNT_W'(MAX_CARDS)) ? CNT_W'(MAX_CARDS) : r_card_count;
        cc_ext   = {{(RAW_W-CNT_W){1'b0}}, card_lim};
        a_ge     = i_address >= r_heap_base;
        a_off    = i_address - r_heap_base;
        a_idx    = a_off[ADDR_BITS-1:CARD_LSB];
        in_range = a_ge && (a_idx < cc_ext);
        e_ge     = i_end_address >= r_heap_base;
        e_off    = i_end_address - r_heap_base;
        e_idx    = e_off[ADDR_BITS-1:CARD_LSB];
        if (!e_ge)
            hi_sel = '0;
        else if (e_idx < cc_ext)
            hi_sel = e_idx[CNT_W-1:0];
        else
            hi_sel = card_lim;
    end

    // card base address, shared by marks and scans
    logic [IDX_W-1:0]     base_idx;
    logic [ADDR_BITS-1:0] card_base;

    assign base_idx  = (r_state == S_MARK) ? r_idx : r_cur[IDX_W-1:0];
    assign card_base = r_heap_base
                     + {{(ADDR_BITS-IDX_W-CARD_LSB){1'b0}}, base_idx, {CARD_LSB{1'b0}}};

    // scan range setup
    logic [CNT_W-1:0] lo_ext, scan_len;
    logic             scan_empty;

    assign lo_ext     = {1'b0, r_lo};
    assign scan_empty = !r_lo_ok || (lo_ext >= r_hi);
    assign scan_len   = r_hi - lo_ext;

    // new state for marks
    t_card mark_val;

    always_comb begin
        unique case (r_op)
            OP_DIRTY: mark_val = ST_DIRTY;
            OP_CLEAN: mark_val = ST_CLEAN;
            default:  mark_val = ST_SCANNED;
        endcase
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_cur         = r_cur;
        n_end         = r_end;
        n_clip        = r_clip;
        n_pend        = r_pend;
        n_pbase       = r_pbase;
        n_found       = r_found;
        n_sw          = r_sw;
        n_pv          = r_pv;
        n_pa          = r_pa;
        n_clr_op      = r_clr_op;
        n_dirty_total = r_dirty_total;
        mem_we        = 1'b0;
        mem_wa        = r_sw;
        mem_wd        = ST_CLEAN;
        mem_re        = 1'b0;
        mem_ra        = r_sw;
        load          = 1'b0;
        n_o_hit       = 1'b0;
        n_o_base      = '0;
        n_o_flag      = 1'b0;
        n_o_count     = '0;
        n_o_clip      = 1'b0;
        o_stall       = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    mem_ra = a_idx[IDX_W-1:0];
                    n_sw   = '0;
                    n_pv   = 1'b0;
                    unique case (i_op)
                        OP_DIRTY, OP_CLEAN, OP_SCANNED, OP_QUERY: begin
                            mem_re  = 1'b1;
                            n_state = S_MARK;
                        end
                        OP_SCAN:       n_state = S_SETUP;
                        OP_CLEAR_ALL: begin
                            n_clr_op      = 1'b1;
                            n_dirty_total = '0;
                            n_state       = S_CLR;
                        end
                        OP_RESET_SCAN: n_state = S_RSW;
                        default:       n_state = S_DONE;
                    endcase
                end
            end

            S_MARK: begin
                if (out_free) begin
                    load = 1'b1;
                    if (r_inr) begin
                        n_o_base = card_base;
                        n_o_flag = (r_op == OP_QUERY) && (r_rdata == ST_DIRTY);
                        if (r_op != OP_QUERY) begin
                            mem_we = 1'b1;
                            mem_wa = r_idx;
                            mem_wd = mark_val;
                            if (r_rdata == ST_DIRTY && mark_val != ST_DIRTY)
                                n_dirty_total = r_dirty_total - 1'b1;
                            else if (r_rdata != ST_DIRTY && mark_val == ST_DIRTY)
                                n_dirty_total = r_dirty_total + 1'b1;
                        end
                    end
                    n_state = S_IDLE;
                end
            end

            S_SETUP: begin
                n_cur   = lo_ext;
                n_pend  = 1'b0;
                n_found = '0;
                n_clip  = 1'b0;
                if (scan_empty) begin
                    n_end = lo_ext;
                end else if (scan_len > CNT_W'(SCAN_SPAN)) begin
                    n_end  = lo_ext + CNT_W'(SCAN_SPAN);
                    n_clip = 1'b1;
                end else begin
                    n_end = r_hi;
                end
                n_state = S_SRD;
            end

            S_SRD: begin
                if (r_cur < r_end) begin
                    mem_re  = 1'b1;
                    mem_ra  = r_cur[IDX_W-1:0];
                    n_state = S_SCHK;
                end else begin
                    n_state = S_SEND;
                end
            end

            // a dirty card is held back until the next one shows whether it is the last
            S_SCHK: begin
                if (r_rdata != ST_DIRTY) begin
                    n_cur   = r_cur + 1'b1;
                    n_state = S_SRD;
                end else if (!r_pend || out_free) begin
                    if (r_pend) begin
                        load      = 1'b1;
                        n_o_hit   = 1'b1;
                        n_o_base  = r_pbase;
                        n_o_count = CNT_W'(r_found);
                    end
                    mem_we        = 1'b1;
                    mem_wa        = r_cur[IDX_W-1:0];
                    mem_wd        = ST_SCANNED;
                    n_dirty_total = r_dirty_total - 1'b1;
                    n_pend        = 1'b1;
                    n_pbase       = card_base;
                    n_found       = r_found + 1'b1;
                    n_cur         = r_cur + 1'b1;
                    n_state       = S_SRD;
                end
            end

            S_SEND: begin
                if (out_free) begin
                    load      = 1'b1;
                    n_o_hit   = r_pend;
                    n_o_base  = r_pend ? r_pbase : '0;
                    n_o_count = r_pend ? CNT_W'(r_found) : '0;
                    n_o_clip  = r_clip;
                    n_state   = S_IDLE;
                end
            end

            // clearing pass: after reset and for clear all
            S_CLR: begin
                mem_we = 1'b1;
                mem_wa = r_sw;
                mem_wd = ST_CLEAN;
                n_sw   = r_sw + 1'b1;
                if (r_sw == LAST_IDX)
                    n_state = r_clr_op ? S_DONE : S_IDLE;
            end

            // scanned-to-clean sweep: read one entry, write back the one before
            S_RSW: begin
                mem_re = 1'b1;
                mem_ra = r_sw;
                n_pv   = 1'b1;
                n_pa   = r_sw;
                n_sw   = r_sw + 1'b1;
                if (r_pv && r_rdata == ST_SCANNED) begin
                    mem_we = 1'b1;
                    mem_wa = r_pa;
                    mem_wd = ST_CLEAN;
                end
                if (r_sw == LAST_IDX)
                    n_state = S_RTAIL;
            end

            S_RTAIL: begin
                if (r_rdata == ST_SCANNED) begin
                    mem_we = 1'b1;
                    mem_wa = r_pa;
                    mem_wd = ST_CLEAN;
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                if (out_free) begin
                    load      = 1'b1;
                    n_o_count = (r_op == OP_COUNT) ? r_dirty_total : '0;
                    n_state   = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLR;
            r_sw          <= '0;
            r_pv          <= 1'b0;
            r_clr_op      <= 1'b0;
            r_dirty_total <= '0;
            r_pend        <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_sw          <= n_sw;
            r_pv          <= n_pv;
            r_clr_op      <= n_clr_op;
            r_dirty_total <= n_dirty_total;
            r_pend        <= n_pend;
            if (load)
                r_o_valid <= 1'b1;
            else if (!i_stall)
                r_o_valid <= 1'b0;
        end
    end

    // request fields and scan working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_op;
            r_idx   <= a_idx[IDX_W-1:0];
            r_inr   <= in_range;
            r_lo    <= a_ge ? a_idx[IDX_W-1:0] : '0;
            r_lo_ok <= a_ge ? in_range : (r_card_count != '0);
            r_hi    <= hi_sel;
        end
        r_cur   <= n_cur;
        r_end   <= n_end;
        r_clip  <= n_clip;
        r_pbase <= n_pbase;
        r_found <= n_found;
        r_pa    <= n_pa;
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_hit   <= n_o_hit;
            r_o_base  <= n_o_base;
            r_o_flag  <= n_o_flag;
            r_o_count <= n_o_count;
            r_o_clip  <= n_o_clip;
            r_o_last  <= !(r_state == S_SCHK);
        end
    end

    assign o_valid      = r_o_valid;
    assign o_hit        = r_o_hit;
    assign o_card_base  = r_o_base;
    assign o_dirty_flag = r_o_flag;
    assign o_count      = r_o_count;
    assign o_clipped    = r_o_clip;
    assign o_last       = r_o_last;

endmodule

`default_nettype wire

// ----- test/tb_gc_card_table_marker_core.sv -----
`timescale 1ns / 1ps

module tb_gc_card_table_marker_core;
    import gctm_pkg::*;

    localparam int STALL_LIMIT  = 300000;  // long enough for a full table sweep with nothing taken
    localparam int HOLD_CYCLES  = 400;
    localparam int END_CYCLES   = 20;
    localparam int MAX_PRINTS   = 100;

    // One result item as the block presents it
    typedef struct packed {
        logic                 hit;
        logic [ADDR_BITS-1:0] card_base;
        logic                 dirty_flag;
        logic [CNT_W-1:0]     count;
        logic                 clipped;
        logic                 last;
    } t_card_res;

    // Stimulus side
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic                 i_cfg_index   = CFG_HEAP_BASE;
    logic [ADDR_BITS-1:0] i_cfg_data    = '0;
    logic                 i_valid       = 1'b0;
    logic [2:0]           i_op          = OP_DIRTY;
    logic [ADDR_BITS-1:0] i_address     = '0;
    logic [ADDR_BITS-1:0] i_end_address = '0;
    logic                 i_stall       = 1'b0;

    // Result side
    wire                  o_stall;
    wire                  o_valid;
    wire                  o_hit;
    wire [ADDR_BITS-1:0]  o_card_base;
    wire                  o_dirty_flag;
    wire [CNT_W-1:0]      o_count;
    wire                  o_clipped;
    wire                  o_last;

    // Mirror of the card table and its layout registers
    t_card                card_marks [MAX_CARDS];
    int unsigned          dirty_cards;
    logic [ADDR_BITS-1:0] layout_base;
    logic [CNT_W-1:0]     layout_cards;
    t_card_res            awaited_results [$];

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_asks    = 0;
    int hold_taken   = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int mismatch_cnt = 0;

    gc_card_table_marker_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_address     (i_address),
        .i_end_address (i_end_address),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hit         (o_hit),
        .o_card_base   (o_card_base),
        .o_dirty_flag  (o_dirty_flag),
        .o_count       (o_count),
        .o_clipped     (o_clipped),
        .o_last        (o_last)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        mismatch_cnt++;
        // keep the log short when everything goes wrong
        if (mismatch_cnt <= MAX_PRINTS)
            $display("MISMATCH %0t: %s", $realtime, what);
    endtask

    // ---------------------------------------------------------------
    // Card table mirror
    // ---------------------------------------------------------------

    function automatic longint unsigned cards_in_use();
        return (layout_cards < MAX_CARDS) ? longint'(layout_cards) : longint'(MAX_CARDS);
    endfunction

    // card index of an address, zero below the heap base
    function automatic longint unsigned card_of(input logic [ADDR_BITS-1:0] a);
        logic [63:0] d;
        if (a < layout_base)
            return 0;
        d = a - layout_base;
        return d >> CARD_LSB;
    endfunction

    function automatic logic [ADDR_BITS-1:0] card_base_of(input longint unsigned idx);
        logic [63:0] v;
        v = layout_base + (idx << CARD_LSB);
        return v[ADDR_BITS-1:0];
    endfunction

    function automatic void set_card(input longint unsigned idx, input t_card st);
        if (card_marks[idx] == ST_DIRTY && st != ST_DIRTY)
            dirty_cards--;
        else if (card_marks[idx] != ST_DIRTY && st == ST_DIRTY)
            dirty_cards++;
        card_marks[idx] = st;
    endfunction

    // Apply one request to the mirror and queue the results it should give
    function automatic void card_op_outcome(input t_op op,
                                            input logic [ADDR_BITS-1:0] a,
                                            input logic [ADDR_BITS-1:0] e);
        t_card_res         r;
        t_card_res         held;
        longint unsigned   idx;
        longint unsigned   lo;
        longint unsigned   hi;
        longint unsigned   i;
        int unsigned       found;
        logic              clip;
        logic              in_rng;
        logic              have_held;
        r      = '0;
        r.last = 1'b1;
        idx    = card_of(a);
        in_rng = (a >= layout_base) && (idx < cards_in_use());
        case (op)
            OP_DIRTY, OP_CLEAN, OP_SCANNED: begin
                if (in_rng) begin
                    set_card(idx, (op == OP_DIRTY) ? ST_DIRTY :
                                  (op == OP_CLEAN) ? ST_CLEAN : ST_SCANNED);
                    r.card_base = card_base_of(idx);
                end
                awaited_results.push_back(r);
            end
            OP_QUERY: begin
                if (in_rng) begin
                    r.card_base  = card_base_of(idx);
                    r.dirty_flag = (card_marks[idx] == ST_DIRTY);
                end
                awaited_results.push_back(r);
            end
            OP_SCAN: begin
                lo   = idx;
                hi   = card_of(e);
                clip = 1'b0;
                if (hi > cards_in_use())
                    hi = cards_in_use();
                if (lo < hi && hi - lo > SCAN_SPAN) begin
                    hi   = lo + SCAN_SPAN;
                    clip = 1'b1;
                end
                found     = 0;
                have_held = 1'b0;
                held      = '0;
                // hold each hit back one step so the final one can be tagged
                for (i = lo; i < hi; i++) begin
                    if (card_marks[i] == ST_DIRTY) begin
                        set_card(i, ST_SCANNED);
                        found++;
                        if (have_held)
                            awaited_results.push_back(held);
                        held           = '0;
                        held.hit       = 1'b1;
                        held.card_base = card_base_of(i);
                        held.count     = CNT_W'(found);
                        have_held      = 1'b1;
                    end
                end
                if (have_held) begin
                    held.clipped = clip;
                    held.last    = 1'b1;
                    awaited_results.push_back(held);
                end else begin
                    r.clipped = clip;
                    awaited_results.push_back(r);
                end
            end
            OP_CLEAR_ALL: begin
                foreach (card_marks[k])
                    card_marks[k] = ST_CLEAN;
                dirty_cards = 0;
                awaited_results.push_back(r);
            end
            OP_RESET_SCAN: begin
                foreach (card_marks[k])
                    if (card_marks[k] == ST_SCANNED)
                        card_marks[k] = ST_CLEAN;
                awaited_results.push_back(r);
            end
            default: begin
                // dirty count, saturated to the field width
                r.count = (dirty_cards > 32'h1FFFF) ? {CNT_W{1'b1}} : CNT_W'(dirty_cards);
                awaited_results.push_back(r);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Result stall: random, or a long hold-off when a test asks for one
    always @(negedge i_clk) begin
        if (hold_asks != hold_taken) begin
            hold_taken = hold_asks;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Offer one request and wait for it to be taken; called and returns at a falling edge
    task automatic send_req(input t_op op, input logic [ADDR_BITS-1:0] a,
                            input logic [ADDR_BITS-1:0] e);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_address     <= a;
        i_end_address <= e;
        @(posedge i_clk);
        while (o_stall !== 1'b0)
            @(posedge i_clk);
        card_op_outcome(op, a, e);
        @(negedge i_clk);
    endtask

    // Stop offering and wait for every pending result
    task automatic drain_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write both layout registers; only called with no results pending
    task automatic write_layout(input logic [ADDR_BITS-1:0] base,
                                input logic [CNT_W-1:0] cards);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_HEAP_BASE;
        i_cfg_data  <= base;
        @(negedge i_clk);
        i_cfg_index <= CFG_CARD_COUNT;
        i_cfg_data  <= {{(ADDR_BITS-CNT_W){1'b0}}, cards};
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
        layout_base  = base;
        layout_cards = cards;
    endtask

    function automatic logic [ADDR_BITS-1:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[ADDR_BITS-1:0];
    endfunction

    // byte address inside card idx of the current layout (idx may be negative)
    function automatic logic [ADDR_BITS-1:0] addr_of(input longint idx, input int offs);
        logic [63:0] v;
        v = 64'(layout_base) + 64'(idx <<< CARD_LSB) + 64'(offs);
        return v[ADDR_BITS-1:0];
    endfunction

    // Random requests, mostly aimed at a window of cards so scans find work
    task automatic run_traffic(input int n, input longint win_lo, input int win_len);
        t_op                  op;
        logic [ADDR_BITS-1:0] a;
        logic [ADDR_BITS-1:0] e;
        longint               idx;
        int                   pick;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 30)
                op = OP_DIRTY;
            else if (pick < 38)
                op = OP_CLEAN;
            else if (pick < 45)
                op = OP_SCANNED;
            else if (pick < 65)
                op = OP_QUERY;
            else if (pick < 90)
                op = OP_SCAN;
            else
                op = OP_COUNT;
            idx = win_lo + longint'($urandom_range(win_len));
            a   = addr_of(idx, $urandom_range(511));
            e   = rand48();
            if (op == OP_SCAN) begin
                if ($urandom_range(9) == 0)
                    e = addr_of(idx - longint'($urandom_range(4)), $urandom_range(511));
                else
                    e = addr_of(idx + longint'($urandom_range(80)), $urandom_range(511));
            end
            // noise: wild addresses, mostly out of range
            if ($urandom_range(99) < 15) begin
                if ($urandom_range(1) == 0)
                    a = rand48();
                else
                    e = rand48();
            end
            send_req(op, a, e);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic test_edge_cases();
        // no cards configured: everything is out of range
        write_layout('0, '0);
        send_req(OP_DIRTY, '0, '0);
        drain_results();

        // small table away from address zero
        write_layout(48'h1000, 17'd16);
        send_req(OP_DIRTY, addr_of(0, 0), '1);
        send_req(OP_DIRTY, addr_of(15, 511), '0);
        send_req(OP_DIRTY, addr_of(5, 17), '0);
        send_req(OP_DIRTY, addr_of(0, -1), '0);     // just below the base
        send_req(OP_DIRTY, addr_of(16, 0), '0);     // one past the last card
        send_req(OP_QUERY, addr_of(0, 300), '0);
        send_req(OP_QUERY, addr_of(1, 0), '0);
        send_req(OP_QUERY, addr_of(16, 0), '0);
        send_req(OP_SCANNED, addr_of(5, 0), '0);
        send_req(OP_CLEAN, addr_of(15, 0), '0);
        send_req(OP_COUNT, '0, '0);
        send_req(OP_SCAN, '0, '1);                  // start saturates, end clamps
        send_req(OP_SCAN, addr_of(8, 0), addr_of(0, -1));  // end below the base
        send_req(OP_SCAN, addr_of(9, 0), addr_of(3, 0));   // reversed range
        send_req(OP_RESET_SCAN, '0, '0);
        send_req(OP_QUERY, addr_of(0, 0), '0);
        drain_results();

        // full table: clipping and the top card
        write_layout('0, 17'd65536);
        send_req(OP_DIRTY, addr_of(10, 0), '0);
        send_req(OP_DIRTY, addr_of(73, 0), '0);
        send_req(OP_DIRTY, addr_of(65535, 511), '0);
        send_req(OP_SCAN, '0, addr_of(100, 0));             // over the span, cut short
        send_req(OP_SCAN, addr_of(10, 0), addr_of(74, 0));  // exactly the span
        send_req(OP_SCAN, addr_of(65500, 0), '1);
        send_req(OP_CLEAR_ALL, '1, '1);
        send_req(OP_COUNT, '0, '0);
        drain_results();

        // base at the very top of the address space
        write_layout('1, 17'd1);
        send_req(OP_DIRTY, '1, '1);
        send_req(OP_COUNT, '1, '1);
    endtask

    task automatic test_traffic_slow_sender();
        logic [CNT_W-1:0] cards;
        tx_idle_pct = 37;
        rx_idle_pct = 50;
        drain_results();
        cards = CNT_W'($urandom_range(200, 40));
        write_layout(rand48() >> 1, cards);
        run_traffic(50, -2, int'(cards) + 8);
        // receiver holds off while requests keep coming
        hold_asks++;
        run_traffic(45, -2, int'(cards) + 8);
        send_req(OP_RESET_SCAN, rand48(), rand48());
        run_traffic(49, -2, int'(cards) + 8);
    endtask

    task automatic test_traffic_slow_receiver();
        tx_idle_pct = 50;
        rx_idle_pct = 37;
        drain_results();
        write_layout(48'hFFFF_FE00_0000, 17'd65536);
        run_traffic(70, 65536 - 150, 160);
        // sender waits for every result before going on
        drain_results();
        send_req(OP_RESET_SCAN, rand48(), rand48());
        run_traffic(74, 65536 - 150, 160);
    endtask

    task automatic test_traffic_full_rate();
        logic [CNT_W-1:0] cards;
        longint           lo;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        drain_results();
        // lowered card count leaves the top cards marked above the limit
        cards = CNT_W'($urandom_range(65535, 2000));
        write_layout(rand48(), cards);
        lo = longint'($urandom_range(cards)) - 60;
        run_traffic(60, lo, 140);
        send_req(OP_RESET_SCAN, rand48(), rand48());
        run_traffic(40, lo, 140);
        send_req(OP_CLEAR_ALL, rand48(), rand48());
        run_traffic(43, lo, 140);
    endtask

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin : check_results
        t_card_res got;
        t_card_res want;
        string     diffs;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            got = {o_hit, o_card_base, o_dirty_flag, o_count, o_clipped, o_last};
            if (awaited_results.size() == 0) begin
                flag_mismatch($sformatf("result with nothing pending: base=%h count=%0d",
                                        got.card_base, got.count));
            end else begin
                want  = awaited_results.pop_front();
                diffs = "";
                if (got.hit !== want.hit)               diffs = {diffs, " hit"};
                if (got.card_base !== want.card_base)   diffs = {diffs, " card_base"};
                if (got.dirty_flag !== want.dirty_flag) diffs = {diffs, " dirty_flag"};
                if (got.count !== want.count)           diffs = {diffs, " count"};
                if (got.clipped !== want.clipped)       diffs = {diffs, " clipped"};
                if (got.last !== want.last)             diffs = {diffs, " last"};
                if (diffs != "")
                    flag_mismatch($sformatf(
                        "bad%s: got %b/%h/%b/%0d/%b/%b want %b/%h/%b/%0d/%b/%b", diffs,
                        got.hit, got.card_base, got.dirty_flag, got.count, got.clipped,
                        got.last, want.hit, want.card_base, want.dirty_flag, want.count,
                        want.clipped, want.last));
            end
        end
    end

    // Watchdog: too long with no request or result taken
    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_gc_card_table_marker_core: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial begin
        foreach (card_marks[k])
            card_marks[k] = ST_CLEAN;
        dirty_cards  = 0;
        layout_base  = '0;
        layout_cards = '0;
        tx_idle_pct  = 37;
        rx_idle_pct  = 50;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_edge_cases();
        test_traffic_slow_sender();
        test_traffic_slow_receiver();
        test_traffic_full_rate();

        drain_results();
        repeat (END_CYCLES) @(negedge i_clk);
        if (awaited_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
        if (mismatch_cnt == 0)
            $display("tb_gc_card_table_marker_core: clean");
        else
            $display("tb_gc_card_table_marker_core: errors");
        $finish;
    end

endmodule

// ----- gc_card_table_marker_core.f -----
hdl/gctm_pkg.sv
hdl/gc_card_table_marker_core.sv
test/tb_gc_card_table_marker_core.sv
